// ===== sv/conv2d_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and a helper for the 3x3 streaming window filter.
// Used by conv2d_3x3_stream_core; depends on nothing else.
package conv2d_pkg;

  localparam int unsigned MAX_COLS_DEF = 1024;

  localparam int unsigned PIX_W       = 8;
  localparam int unsigned VAL_W       = 20;
  localparam int unsigned DIM_W       = 11;
  localparam int unsigned SHIFT_W     = 5;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 24;
  localparam int unsigned PROD_W      = 17;
  localparam int unsigned SUM_W       = 21;
  localparam int unsigned TDATA_IN_W  = 8;
  localparam int unsigned TDATA_OUT_W = 24;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_ROW0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_ROW1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_ROW2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_MODE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FLIP_KERNEL  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_SHIFT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS   = 3'd7;

  // Pad modes; the unused fourth code behaves as zero padding.
  localparam logic [1:0] PAD_NONE  = 2'd0;
  localparam logic [1:0] PAD_FIRST = 2'd2;

  // Input beat kinds carried in tuser.
  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [2:0]       pix_trio_t;
  typedef pix_trio_t [2:0]  win_t;      // [row][column], column 2 newest

  // Control that travels with an item from the input register to the window stage.
  typedef struct packed {
    logic drain;        // drain beat instead of a pixel
    logic drain_first;  // first drain beat of the frame
    logic pad_a;        // column read on port A lies beyond the frame
    logic emit;         // first result is produced
    logic two;          // a second result follows (right edge, padded)
    logic row_one;      // top window row is outside the frame
    logic col_one;      // left window column is outside the frame
    logic last;         // first result closes the frame
    pix_t pv;           // pad value seen by this item
    pix_t px;           // incoming pixel
  } s1_ctrl_t;

  function automatic logic signed [PIX_W-1:0] coef_byte(input logic [CFG_DATA_W-1:0] word,
                                                        input logic [1:0] idx);
    logic [PIX_W-1:0] b;
    case (idx)
      2'd0:    b = word[7:0];
      2'd1:    b = word[15:8];
      default: b = word[23:16];
    endcase
    return $signed(b);
  endfunction

endpackage

// ===== sv/conv2d_3x3_stream_core.sv =====
`timescale 1ns / 1ps
// Streaming 3x3 convolution / correlation over raster pixels, with two line stores.
// Depends on conv2d_pkg for constants, types and the coefficient helper.
//
//   channel  direction  signals                                     beat
//   cfg      in         cfg_valid_i/cfg_ready_o/cfg_index_i/cfg_data_i  one register write
//   s_axis   in         tvalid/tready/tdata/tuser                   pixel or drain item
//   m_axis   out        tvalid/tready/tdata/tlast                   one filtered pixel
//
// One input beat is taken per clock while the window stage can move on. In a padded
// mode the pixel in the last column of a row gives two results and holds the input
// until the second has moved on. A result passes these registers to m_axis: input
// register with line store read, window, products, sum, shift and output register.
// Back pressure on m_axis propagates stage by stage; a stage with a bubble still moves.
// Reset clears control state and the window; the line stores need no clearing pass.
module conv2d_3x3_stream_core #(
  parameter int unsigned MAX_COLS = conv2d_pkg::MAX_COLS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [conv2d_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [conv2d_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [conv2d_pkg::TDATA_IN_W-1:0]      s_axis_tdata,   // [7:0] pixel
  input  logic [0:0]                             s_axis_tuser,   // [0] func
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [conv2d_pkg::TDATA_OUT_W-1:0]     m_axis_tdata,   // [19:0] value, rest zero
  output logic                                   m_axis_tlast
);
  import conv2d_pkg::*;

  localparam int unsigned COL_W = $clog2(MAX_COLS + 1);
  localparam int unsigned ADDR_W = $clog2(MAX_COLS);
  localparam int unsigned TD_FILL = TDATA_OUT_W - VAL_W;

  // ---------------- configuration ----------------
  logic [2:0][CFG_DATA_W-1:0] kern_q;
  logic [1:0]                 pad_mode_q;
  logic                       flip_q;
  logic [SHIFT_W-1:0]         shift_q;
  logic [DIM_W-1:0]           cols_cfg_q;
  logic [DIM_W-1:0]           rows_cfg_q;
  logic                       cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kern_q     <= '0;
      pad_mode_q <= PAD_NONE;
      flip_q     <= 1'b1;
      shift_q    <= '0;
      cols_cfg_q <= DIM_W'(3);
      rows_cfg_q <= DIM_W'(3);
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        REG_KERNEL_ROW0:  kern_q[0]  <= cfg_data_i;
        REG_KERNEL_ROW1:  kern_q[1]  <= cfg_data_i;
        REG_KERNEL_ROW2:  kern_q[2]  <= cfg_data_i;
        REG_PAD_MODE:     pad_mode_q <= cfg_data_i[1:0];
        REG_FLIP_KERNEL:  flip_q     <= cfg_data_i[0];
        REG_OUTPUT_SHIFT: shift_q    <= cfg_data_i[SHIFT_W-1:0];
        REG_IMAGE_COLS:   cols_cfg_q <= cfg_data_i[DIM_W-1:0];
        REG_IMAGE_ROWS:   rows_cfg_q <= cfg_data_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  logic [COL_W-1:0] cols_eff;
  logic [DIM_W-1:0] rows_eff;
  logic             padded;

  always_comb begin
    if (cols_cfg_q < DIM_W'(3)) begin
      cols_eff = COL_W'(3);
    end else if (32'(cols_cfg_q) > 32'(MAX_COLS)) begin
      cols_eff = COL_W'(MAX_COLS);
    end else begin
      cols_eff = COL_W'(cols_cfg_q);
    end
  end

  assign rows_eff = (rows_cfg_q < DIM_W'(3)) ? DIM_W'(3) : rows_cfg_q;
  assign padded = pad_mode_q != PAD_NONE;

  // ---------------- input register, positions and line store reads ----------------
  logic [DIM_W-1:0] row_q, row_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [COL_W-1:0] drain_q, drain_d;
  pix_t             ffp_q, ffp_d;

  logic             s_accept, ready1, is_drain;
  pix_t             px, pv_pix, pv_cur, ffp_next;
  logic             row_wrap, new_frame, drain_ok, drain_end;
  logic [DIM_W-1:0] rp, rp_next;
  logic [COL_W-1:0] cp_raw, cp, col_next, drain_next;
  logic             s1_load, lo_we;
  s1_ctrl_t         s1_d, s1_q;
  logic [ADDR_W-1:0] rd_a_addr, s1_addr_q;

  assign s_axis_tready = ready1;
  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign is_drain = s_axis_tuser[0] == FUNC_DRAIN;
  assign px = s_axis_tdata[PIX_W-1:0];

  assign row_wrap = row_q >= rows_eff;
  assign rp = row_wrap ? '0 : row_q;
  assign rp_next = rp + DIM_W'(1);
  assign cp_raw = row_wrap ? '0 : col_q;
  assign cp = (cp_raw >= cols_eff) ? '0 : cp_raw;
  assign col_next = cp + COL_W'(1);
  assign new_frame = (rp == '0) && (cp == '0);
  assign ffp_next = new_frame ? px : ffp_q;
  assign pv_pix = (pad_mode_q == PAD_FIRST) ? ffp_next : '0;
  assign pv_cur = (pad_mode_q == PAD_FIRST) ? ffp_q : '0;
  assign drain_ok = padded && (row_q == rows_eff);
  assign drain_end = drain_q >= cols_eff;
  assign drain_next = drain_q + COL_W'(1);

  always_comb begin
    row_d     = row_q;
    col_d     = col_q;
    drain_d   = drain_q;
    ffp_d     = ffp_q;
    s1_load   = 1'b0;
    lo_we     = 1'b0;
    s1_d      = '0;
    rd_a_addr = cp[ADDR_W-1:0];
    if (s_accept) begin
      if (is_drain) begin
        if (drain_ok) begin
          if (drain_end) begin
            row_d   = '0;
            col_d   = '0;
            drain_d = '0;
          end else begin
            s1_load          = 1'b1;
            s1_d.drain       = 1'b1;
            s1_d.drain_first = drain_q == '0;
            s1_d.pad_a       = drain_next >= cols_eff;
            s1_d.emit        = 1'b1;
            s1_d.last        = drain_next == cols_eff;
            s1_d.pv          = pv_cur;
            rd_a_addr        = drain_next[ADDR_W-1:0];
            drain_d          = drain_next;
            if (drain_next >= cols_eff) begin
              row_d   = '0;
              col_d   = '0;
              drain_d = '0;
            end
          end
        end
      end else begin
        s1_load = 1'b1;
        lo_we   = 1'b1;
        ffp_d   = ffp_next;
        s1_d.px = px;
        s1_d.pv = pv_pix;
        if (padded) begin
          s1_d.emit    = (rp >= DIM_W'(1)) && (cp >= COL_W'(1));
          s1_d.two     = s1_d.emit && (cp == cols_eff - COL_W'(1));
          s1_d.row_one = rp == DIM_W'(1);
          s1_d.col_one = cp == COL_W'(1);
        end else begin
          s1_d.emit = (rp >= DIM_W'(2)) && (cp >= COL_W'(2));
          s1_d.last = s1_d.emit && (rp == rows_eff - DIM_W'(1))
                      && (cp == cols_eff - COL_W'(1));
        end
        if (row_wrap) begin
          drain_d = '0;
        end
        if (col_next >= cols_eff) begin
          col_d = '0;
          row_d = rp_next;
        end else begin
          col_d = col_next;
          row_d = rp;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      col_q   <= '0;
      drain_q <= '0;
      ffp_q   <= '0;
    end else begin
      row_q   <= row_d;
      col_q   <= col_d;
      drain_q <= drain_d;
      ffp_q   <= ffp_d;
    end
  end

  // Line stores: upper holds the row two above, lower the row just above.
  // Port B reads column 0, which only the first drain beat needs.
  pix_t up_mem [MAX_COLS];
  pix_t lo_mem [MAX_COLS];
  pix_t up_a_q, lo_a_q, up_b_q, lo_b_q;
  logic up_we;

  always_ff @(posedge clk_i) begin
    if (lo_we) begin
      lo_mem[cp[ADDR_W-1:0]] <= px;
    end
    if (up_we) begin
      up_mem[s1_addr_q] <= lo_a_q;
    end
    if (s1_load) begin
      up_a_q    <= up_mem[rd_a_addr];
      lo_a_q    <= lo_mem[rd_a_addr];
      up_b_q    <= up_mem[ADDR_W'(0)];
      lo_b_q    <= lo_mem[ADDR_W'(0)];
      s1_q      <= s1_d;
      s1_addr_q <= cp[ADDR_W-1:0];
    end
  end

  // ---------------- window stage ----------------
  logic      v1_q, phase_q;
  win_t      win_q, wn, a0, a1, a_sel;
  pix_trio_t new_col;
  logic      emit_now, s1_step, s1_done, s2_load, ready2;

  always_comb begin
    if (s1_q.drain) begin
      new_col[0] = s1_q.pad_a ? s1_q.pv : up_a_q;
      new_col[1] = s1_q.pad_a ? s1_q.pv : lo_a_q;
      new_col[2] = s1_q.pv;
    end else begin
      new_col[0] = up_a_q;
      new_col[1] = lo_a_q;
      new_col[2] = s1_q.px;
    end
    for (int k = 0; k < 3; k++) begin
      wn[k][0] = win_q[k][1];
      wn[k][1] = win_q[k][2];
      wn[k][2] = new_col[k];
    end
    // The first drain beat rebuilds the window from the pad value and columns 0 and 1.
    if (s1_q.drain_first) begin
      for (int k = 0; k < 3; k++) begin
        wn[k][0] = s1_q.pv;
      end
      wn[0][1] = up_b_q;
      wn[1][1] = lo_b_q;
      wn[2][1] = s1_q.pv;
    end
    a0 = wn;
    if (s1_q.row_one) begin
      a0[0] = {3{s1_q.pv}};
    end
    if (s1_q.col_one) begin
      for (int k = 0; k < 3; k++) begin
        a0[k][0] = s1_q.pv;
      end
    end
    // Second result at the right edge: window moved one more column into the pad.
    for (int k = 0; k < 3; k++) begin
      a1[k][0] = win_q[k][1];
      a1[k][1] = win_q[k][2];
      a1[k][2] = s1_q.pv;
    end
    if (s1_q.row_one) begin
      a1[0] = {3{s1_q.pv}};
    end
    a_sel = phase_q ? a1 : a0;
  end

  assign emit_now = phase_q || s1_q.emit;
  assign s1_step = v1_q && (!emit_now || ready2);
  assign s1_done = s1_step && (phase_q || !s1_q.two);
  assign ready1 = !v1_q || s1_done;
  assign s2_load = s1_step && emit_now;
  assign up_we = s1_step && !phase_q && !s1_q.drain;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      phase_q <= 1'b0;
      win_q   <= '0;
    end else begin
      if (s1_load) begin
        v1_q <= 1'b1;
      end else if (s1_done) begin
        v1_q <= 1'b0;
      end
      if (s1_step) begin
        phase_q <= !phase_q && s1_q.two;
      end
      if (s1_step && !phase_q) begin
        win_q <= wn;
      end
    end
  end

  // ---------------- products ----------------
  logic signed [PIX_W-1:0] coef [3][3];

  for (genvar k = 0; k < 3; k++) begin : g_coef_row
    for (genvar p = 0; p < 3; p++) begin : g_coef_col
      assign coef[k][p] = flip_q ? coef_byte(kern_q[2-k], 2'(2-p))
                                 : coef_byte(kern_q[k], 2'(p));
    end
  end

  logic                     v2_q, last2_q, ready3;
  win_t                     a2_q;
  logic                     v3_q, last3_q, ready4;
  logic signed [PROD_W-1:0] prod_q [3][3];

  assign ready2 = !v2_q || ready3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (ready2) begin
      v2_q <= s2_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      a2_q    <= a_sel;
      last2_q <= !phase_q && s1_q.last;
    end
  end

  assign ready3 = !v3_q || ready4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (ready3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready3 && v2_q) begin
      last3_q <= last2_q;
      for (int k = 0; k < 3; k++) begin
        for (int p = 0; p < 3; p++) begin
          prod_q[k][p] <= $signed({1'b0, a2_q[k][p]}) * coef[k][p];
        end
      end
    end
  end

  // ---------------- sum ----------------
  logic                    v4_q, last4_q, ready_out;
  logic signed [SUM_W-1:0] sum_d, sum_q;

  always_comb begin
    sum_d = '0;
    for (int k = 0; k < 3; k++) begin
      for (int p = 0; p < 3; p++) begin
        sum_d = sum_d + SUM_W'(prod_q[k][p]);
      end
    end
  end

  assign ready4 = !v4_q || ready_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (ready4) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready4 && v3_q) begin
      sum_q   <= sum_d;
      last4_q <= last3_q;
    end
  end

  // ---------------- shift and output register ----------------
  logic                    out_valid_q, out_last_q;
  logic [VAL_W-1:0]        out_value_q;
  logic signed [SUM_W-1:0] shifted;

  assign shifted = sum_q >>> shift_q;
  assign ready_out = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ready_out) begin
      out_valid_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_out && v4_q) begin
      out_value_q <= shifted[VAL_W-1:0];
      out_last_q  <= last4_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {TD_FILL'(0), out_value_q};
  assign m_axis_tlast  = out_last_q;

  // ---------------- assertions ----------------
  // The second result of an edge pixel only exists while that item sits in the window stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> (v1_q && s1_q.two))
    else $error("second-result phase without a two-result item");

  // Every accepted pixel beat must reach the window stage, since it updates the line stores.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && (s_axis_tuser[0] == FUNC_PIXEL)) |=> v1_q)
    else $error("pixel beat accepted but window stage empty");

  // While the second result waits on a full product stage, no new beat may enter.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q && !ready2) |-> !s_axis_tready)
    else $error("input taken while the edge result is still pending");

endmodule
